[src/rfac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rfac_pkg;

  // Request codes carried on req_type.
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Bit positions inside reg_flags.
  localparam int FLAG_VALID = 0;
  localparam int FLAG_INV   = 1;
  localparam int FLAG_WO    = 2;
  localparam int FLAG_W1C   = 3;

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } rfac_state_t;

  // Request held between the lookup cycle and the completion cycle.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] reg_offset;
    logic [2:0] field_shift;
    logic [7:0] field_mask;
    logic [3:0] reg_flags;
    logic [7:0] write_value;
    logic       access;
    logic       load;
    logic       write_back;
  } rfac_req_t;

endpackage

`default_nettype wire

[src/rfac_store.sv]
`timescale 1ns / 1ps
`default_nettype none

// Register byte store: one write port, one read port with registered data.
// Entries that were never written since reset read as zero.
module rfac_store #(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
  input  wire logic [7:0]               wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
  output logic      [7:0]               rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [7:0]       mem_q_r;
  logic             hit_r;
  logic             fwd_r;
  logic [7:0]       fwd_data_r;

  // Storage array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_idx];
    end
  end

  // Per-entry written bits give the cleared-at-reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_idx] <= 1'b1;
    end
  end

  // Read side qualifiers, with write-first forwarding on an address match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= written_r[rd_idx];
      fwd_r <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (hit_r ? mem_q_r : 8'h00);

endmodule

`default_nettype wire

[src/register_field_access_cache_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                       Handshake
// input     in_req_type .. in_write_value               in_valid / in_ready
// result    out_status .. out_bus_read_valid            out_valid / out_ready
//
// Each item passes an accept step, which looks up the cache and issues the
// store read (and any write-back), and a completion step, which merges the
// loaded byte and updates the cache. The registered store read sets this split.
// Reset clears the cache and marks every store entry as zero through per-entry
// written bits; no clearing pass is needed. While a result waits, the input
// stays ready for one more item, which is then held in its completion state.
module register_field_access_cache_top #(
  parameter int REG_COUNT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_reg_offset,
  input  wire logic [2:0] in_field_shift,
  input  wire logic [7:0] in_field_mask,
  input  wire logic [3:0] in_reg_flags,
  input  wire logic [7:0] in_write_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_status,
  output logic      [7:0] out_read_value,
  output logic            out_bus_write_valid,
  output logic      [7:0] out_bus_write_addr,
  output logic      [7:0] out_bus_write_data,
  output logic            out_bus_read_valid
);
  import rfac_pkg::*;

  // Offsets are eight bits, so only the first 256 entries can ever be used.
  localparam int DEPTH = (REG_COUNT < 256) ? REG_COUNT : 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int MOD_W = 17;

  // Offset modulo DEPTH by restoring subtraction; four steps cover 8 bits if
  // DEPTH >= 16, which the user must ensure; the block does not enforce it.
  function automatic logic [IDX_W-1:0] store_idx(input logic [7:0] off);
    logic [MOD_W-1:0] v;
    logic [MOD_W-1:0] d;
    v = {{(MOD_W-8){1'b0}}, off};
    for (int k = 3; k >= 0; k--) begin
      d = MOD_W'(DEPTH) << k;
      if (v >= d) begin
        v = v - d;
      end
    end
    return v[IDX_W-1:0];
  endfunction

  rfac_state_t state_r, state_nxt;
  rfac_req_t   req_r;

  logic       cached_valid_r, cached_valid_nxt;
  logic [7:0] cached_offset_r, cached_offset_nxt;
  logic [3:0] cached_flags_r, cached_flags_nxt;
  logic [7:0] read_image_r, read_image_nxt;
  logic [7:0] write_image_r, write_image_nxt;
  logic       write_pending_r, write_pending_nxt;

  logic       out_valid_r;
  logic       out_status_r;
  logic [7:0] out_read_value_r;
  logic       out_bus_write_valid_r;
  logic [7:0] out_bus_write_addr_r;
  logic [7:0] out_bus_write_data_r;
  logic       out_bus_read_valid_r;

  logic       in_fire;
  logic       finish;
  logic       is_access;
  logic       hit;
  logic       need_load;
  logic       need_wb;
  logic [7:0] ld_data;

  // Completion-cycle datapath.
  logic       inv;
  logic       keep_read;
  logic [7:0] base_ri;
  logic [7:0] base_wi;
  logic [7:0] wv;
  logic [7:0] field;
  logic [7:0] clr;
  logic [7:0] rimg;
  logic [7:0] merged_wi;
  logic [7:0] rd_field;

  // Lookup decisions taken from the cache at acceptance.
  always_comb begin
    is_access = ((in_req_type == REQ_READ) || (in_req_type == REQ_WRITE)) &&
                in_reg_flags[FLAG_VALID];
    hit       = cached_valid_r && (cached_offset_r == in_reg_offset);
    need_load = is_access && (!hit || (cached_flags_r != in_reg_flags));
    need_wb   = write_pending_r && (need_load || (in_req_type == REQ_FLUSH));
  end

  rfac_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && need_wb),
    .wr_idx  (store_idx(cached_offset_r)),
    .wr_data (write_image_r),
    .rd_en   (in_fire && need_load),
    .rd_idx  (store_idx(in_reg_offset)),
    .rd_data (ld_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    finish   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_LOOKUP: finish   = !out_valid_r || out_ready;
      default:   ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.req_type    <= in_req_type;
      req_r.reg_offset  <= in_reg_offset;
      req_r.field_shift <= in_field_shift;
      req_r.field_mask  <= in_field_mask;
      req_r.reg_flags   <= in_reg_flags;
      req_r.write_value <= in_write_value;
      req_r.access      <= is_access;
      req_r.load        <= need_load;
      req_r.write_back  <= need_wb;
    end
  end

  // Field merge and extract on the loaded or cached images.
  always_comb begin
    inv       = req_r.reg_flags[FLAG_INV];
    keep_read = req_r.reg_flags[FLAG_WO] || req_r.reg_flags[FLAG_W1C];
    base_ri   = req_r.load ? ld_data : read_image_r;
    base_wi   = req_r.load ? (keep_read ? 8'h00 : ld_data) : write_image_r;
    wv        = inv ? ~req_r.write_value : req_r.write_value;
    field     = (wv & req_r.field_mask) << req_r.field_shift;
    clr       = req_r.field_mask << req_r.field_shift;
    merged_wi = (base_wi & ~clr) | field;
    rimg      = inv ? ~base_ri : base_ri;
    rd_field  = (rimg >> req_r.field_shift) & req_r.field_mask;
  end

  // Cache update for the completing item.
  always_comb begin
    cached_valid_nxt  = cached_valid_r;
    cached_offset_nxt = cached_offset_r;
    cached_flags_nxt  = cached_flags_r;
    read_image_nxt    = read_image_r;
    write_image_nxt   = write_image_r;
    write_pending_nxt = write_pending_r;
    if (req_r.req_type == REQ_FLUSH) begin
      cached_valid_nxt  = 1'b0;
      write_pending_nxt = 1'b0;
    end else if (req_r.access) begin
      if (req_r.load) begin
        cached_valid_nxt  = 1'b1;
        cached_offset_nxt = req_r.reg_offset;
        cached_flags_nxt  = req_r.reg_flags;
      end
      if (req_r.req_type == REQ_WRITE) begin
        write_image_nxt   = merged_wi;
        read_image_nxt    = keep_read ? base_ri : merged_wi;
        write_pending_nxt = 1'b1;
      end else begin
        read_image_nxt    = base_ri;
        write_image_nxt   = keep_read ? base_wi : base_ri;
        write_pending_nxt = req_r.load ? 1'b0 : write_pending_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cached_valid_r  <= 1'b0;
      cached_offset_r <= '0;
      cached_flags_r  <= '0;
      read_image_r    <= '0;
      write_image_r   <= '0;
      write_pending_r <= 1'b0;
    end else if (finish) begin
      cached_valid_r  <= cached_valid_nxt;
      cached_offset_r <= cached_offset_nxt;
      cached_flags_r  <= cached_flags_nxt;
      read_image_r    <= read_image_nxt;
      write_image_r   <= write_image_nxt;
      write_pending_r <= write_pending_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r          <= ((req_r.req_type == REQ_READ) ||
                                (req_r.req_type == REQ_WRITE)) && !req_r.access;
      out_read_value_r      <= (req_r.access && (req_r.req_type == REQ_READ)) ?
                               rd_field : 8'h00;
      out_bus_write_valid_r <= req_r.write_back;
      out_bus_write_addr_r  <= req_r.write_back ? cached_offset_r : 8'h00;
      out_bus_write_data_r  <= req_r.write_back ? write_image_r : 8'h00;
      out_bus_read_valid_r  <= req_r.load;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_value      = out_read_value_r;
  assign out_bus_write_valid = out_bus_write_valid_r;
  assign out_bus_write_addr  = out_bus_write_addr_r;
  assign out_bus_write_data  = out_bus_write_data_r;
  assign out_bus_read_valid  = out_bus_read_valid_r;

endmodule

`default_nettype wire

[src/rfac_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rfac_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_status,
  input wire logic [7:0] out_read_value,
  input wire logic       out_bus_write_valid,
  input wire logic [7:0] out_bus_write_addr,
  input wire logic [7:0] out_bus_write_data,
  input wire logic       out_bus_read_valid
);

  // One item at a time: the input closes for the cycle after an accepted item.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // An invalid-register result touches neither the bus nor the read value.
  a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |->
      (out_read_value == 8'h00 && !out_bus_write_valid && !out_bus_read_valid))
    else $error("invalid-register item caused bus activity");

  // Without a write-back the bus write fields are zero.
  a_no_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bus_write_valid) |->
      (out_bus_write_addr == 8'h00 && out_bus_write_data == 8'h00))
    else $error("bus write fields set without a write-back");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_read_value) &&
       $stable(out_bus_write_valid) && $stable(out_bus_write_addr) &&
       $stable(out_bus_write_data) && $stable(out_bus_read_valid)))
    else $error("result changed while stalled");

endmodule

bind register_field_access_cache_top rfac_checker u_rfac_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rfac_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Flag encodings built from the package bit positions.
  localparam logic [3:0] F_VALID = 4'(1 << FLAG_VALID);
  localparam logic [3:0] F_INV   = 4'(1 << FLAG_INV);
  localparam logic [3:0] F_WO    = 4'(1 << FLAG_WO);
  localparam logic [3:0] F_W1C   = 4'(1 << FLAG_W1C);

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] reg_offset;
    logic [2:0] field_shift;
    logic [7:0] field_mask;
    logic [3:0] reg_flags;
    logic [7:0] write_value;
  } access_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_value;
    logic       bus_write_valid;
    logic [7:0] bus_write_addr;
    logic [7:0] bus_write_data;
    logic       bus_read_valid;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = '0;
  logic [7:0] in_reg_offset = '0;
  logic [2:0] in_field_shift = '0;
  logic [7:0] in_field_mask = '0;
  logic [3:0] in_reg_flags = '0;
  logic [7:0] in_write_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic [7:0] out_read_value;
  logic out_bus_write_valid;
  logic [7:0] out_bus_write_addr;
  logic [7:0] out_bus_write_data;
  logic out_bus_read_valid;

  register_field_access_cache_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_reg_offset       (in_reg_offset),
    .in_field_shift      (in_field_shift),
    .in_field_mask       (in_field_mask),
    .in_reg_flags        (in_reg_flags),
    .in_write_value      (in_write_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_read_value      (out_read_value),
    .out_bus_write_valid (out_bus_write_valid),
    .out_bus_write_addr  (out_bus_write_addr),
    .out_bus_write_data  (out_bus_write_data),
    .out_bus_read_valid  (out_bus_read_valid)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the cache line and the register store.
  logic       line_valid;
  logic [7:0] line_offset;
  logic [3:0] line_flags;
  logic [7:0] line_read_img;
  logic [7:0] line_write_img;
  logic       line_pending;
  logic [7:0] reg_bytes [256];

  access_t pending_accesses[$];
  result_t expected_results[$];
  access_t driven_access;
  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_reads = 0, n_writes = 0, n_flushes = 0, n_unused = 0, n_invalid = 0;
  int unsigned n_writebacks = 0, n_loads = 0;
  logic [7:0] hot_offset [4];
  logic [3:0] hot_flags [4];

  // Write back the pending byte, if any, and drop the cached line.
  function automatic void retire_line(inout result_t r);
    if (line_pending) begin
      reg_bytes[line_offset] = line_write_img;
      r.bus_write_valid = 1'b1;
      r.bus_write_addr = line_offset;
      r.bus_write_data = line_write_img;
      n_writebacks++;
    end
    line_valid = 1'b0;
    line_pending = 1'b0;
  endfunction

  // Work out the result of one access and advance the mirrored state.
  function automatic result_t predict_access(input access_t a);
    result_t r;
    logic keep_read;
    logic [7:0] v, field, clr, img;
    r = '0;
    if (a.req_type == REQ_UNUSED) begin
      n_unused++;
      return r;
    end
    if (a.req_type == REQ_FLUSH) begin
      n_flushes++;
      retire_line(r);
      return r;
    end
    if (!a.reg_flags[FLAG_VALID]) begin
      n_invalid++;
      r.status = 1'b1;
      return r;
    end
    keep_read = a.reg_flags[FLAG_WO] | a.reg_flags[FLAG_W1C];
    // Same register opened with other flags: write back and reload.
    if (line_valid && line_offset == a.reg_offset && line_flags != a.reg_flags)
      retire_line(r);
    if (!(line_valid && line_offset == a.reg_offset)) begin
      retire_line(r);
      line_read_img = reg_bytes[a.reg_offset];
      line_write_img = keep_read ? 8'h00 : line_read_img;
      line_valid = 1'b1;
      line_offset = a.reg_offset;
      line_flags = a.reg_flags;
      r.bus_read_valid = 1'b1;
      n_loads++;
    end
    if (a.req_type == REQ_WRITE) begin
      n_writes++;
      v = a.reg_flags[FLAG_INV] ? ~a.write_value : a.write_value;
      field = (v & a.field_mask) << a.field_shift;
      clr = a.field_mask << a.field_shift;
      line_write_img = (line_write_img & ~clr) | field;
      line_pending = 1'b1;
      if (!keep_read) line_read_img = line_write_img;
    end else begin
      n_reads++;
      img = a.reg_flags[FLAG_INV] ? ~line_read_img : line_read_img;
      r.read_value = (img >> a.field_shift) & a.field_mask;
      if (!keep_read) line_write_img = line_read_img;
    end
    return r;
  endfunction

  task automatic queue_access(input logic [1:0] req, input logic [7:0] off,
                              input logic [2:0] sh, input logic [7:0] mask,
                              input logic [3:0] flags, input logic [7:0] wval);
    access_t a;
    a = '{req, off, sh, mask, flags, wval};
    pending_accesses.push_back(a);
    issued_count++;
  endtask

  // Mostly accesses to a few hot registers so that hits and merges chain up.
  function automatic access_t random_access();
    access_t a;
    int unsigned sel, h, w;
    sel = $urandom_range(99);
    a.req_type = (sel < 42) ? REQ_READ : (sel < 84) ? REQ_WRITE :
                 (sel < 94) ? REQ_FLUSH : REQ_UNUSED;
    a.field_shift = 3'($urandom);
    w = $urandom_range(8);
    a.field_mask = $urandom_range(1) ? 8'((9'd1 << w) - 9'd1) : 8'($urandom);
    a.write_value = 8'($urandom);
    h = $urandom_range(3);
    if ($urandom_range(3) != 0) begin
      a.reg_offset = hot_offset[h];
      a.reg_flags = ($urandom_range(9) == 0) ? (4'($urandom) | F_VALID) : hot_flags[h];
    end else begin
      a.reg_offset = 8'($urandom);
      a.reg_flags = 4'($urandom) | F_VALID;
    end
    if ($urandom_range(19) == 0) a.reg_flags[FLAG_VALID] = 1'b0;
    return a;
  endfunction

  // Wait until every queued item has been accepted and answered.
  task automatic wait_drained();
    while (accepted_count != issued_count || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    for (int i = 0; i < 4; i++) begin
      hot_offset[i] = 8'($urandom);
      hot_flags[i] = 4'($urandom) | F_VALID;
    end
    hot_offset[0] = $urandom_range(1) ? 8'h00 : 8'hFF;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      pending_accesses.push_back(random_access());
      issued_count++;
    end
    wait_drained();
  endtask

  // Driver: presents queued items and records the expected result on accept.
  always @(posedge clk) begin : driver
    access_t nxt;
    logic drive;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drive = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_access(driven_access));
        accepted_count++;
        drive = 1'b0;
      end
      if (!drive && pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_accesses.pop_front();
        driven_access = nxt;
        in_req_type <= nxt.req_type;
        in_reg_offset <= nxt.reg_offset;
        in_field_shift <= nxt.field_shift;
        in_field_mask <= nxt.field_mask;
        in_reg_flags <= nxt.reg_flags;
        in_write_value <= nxt.write_value;
        drive = 1'b1;
      end
      in_valid <= drive;
    end
  end

  task automatic check_result(input result_t exp, input result_t act);
    if (act.status !== exp.status) begin
      $error("status: expected %h, got %h", exp.status, act.status);
      mismatch_count++;
    end
    if (act.read_value !== exp.read_value) begin
      $error("read_value: expected %h, got %h", exp.read_value, act.read_value);
      mismatch_count++;
    end
    if (act.bus_write_valid !== exp.bus_write_valid) begin
      $error("bus_write_valid: expected %h, got %h", exp.bus_write_valid,
             act.bus_write_valid);
      mismatch_count++;
    end
    if (act.bus_write_addr !== exp.bus_write_addr) begin
      $error("bus_write_addr: expected %h, got %h", exp.bus_write_addr,
             act.bus_write_addr);
      mismatch_count++;
    end
    if (act.bus_write_data !== exp.bus_write_data) begin
      $error("bus_write_data: expected %h, got %h", exp.bus_write_data,
             act.bus_write_data);
      mismatch_count++;
    end
    if (act.bus_read_valid !== exp.bus_read_valid) begin
      $error("bus_read_valid: expected %h, got %h", exp.bus_read_valid,
             act.bus_read_valid);
      mismatch_count++;
    end
  endtask

  // Monitor: random back-pressure and comparison of each accepted result.
  always @(posedge clk) begin : monitor
    result_t act;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        act = '{out_status, out_read_value, out_bus_write_valid, out_bus_write_addr,
                out_bus_write_data, out_bus_read_valid};
        if (expected_results.size() == 0) begin
          $error("unexpected result item: status %h read_value %h", act.status,
                 act.read_value);
          mismatch_count++;
        end else begin
          check_result(expected_results.pop_front(), act);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    line_valid = 1'b0;
    line_offset = '0;
    line_flags = '0;
    line_read_img = '0;
    line_write_img = '0;
    line_pending = 1'b0;
    for (int i = 0; i < 256; i++) reg_bytes[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: hits, merges, flag changes, flushes, edge fields.
    queue_access(REQ_READ,   8'h00, 3'd0, 8'hFF, F_VALID, 8'h00);
    queue_access(REQ_WRITE,  8'h00, 3'd0, 8'hFF, F_VALID, 8'hA5);
    queue_access(REQ_READ,   8'h00, 3'd0, 8'hFF, F_VALID, 8'h00);
    // Same register, other flags: write back then reload inverted.
    queue_access(REQ_READ,   8'h00, 3'd0, 8'hFF, F_VALID | F_INV, 8'h00);
    queue_access(REQ_WRITE,  8'h00, 3'd4, 8'h0F, F_VALID | F_INV, 8'h0F);
    // Field beyond the byte on write and on inverted read.
    queue_access(REQ_WRITE,  8'hFF, 3'd7, 8'hFF, F_VALID, 8'hFF);
    queue_access(REQ_READ,   8'hFF, 3'd7, 8'hFF, F_VALID, 8'h00);
    queue_access(REQ_READ,   8'hFF, 3'd7, 8'hFF, F_VALID | F_INV, 8'h00);
    queue_access(REQ_FLUSH,  8'h5A, 3'd5, 8'hC3, 4'hE, 8'h77);
    queue_access(REQ_FLUSH,  8'hFF, 3'd7, 8'hFF, 4'hF, 8'hFF);
    queue_access(REQ_READ,   8'hFF, 3'd0, 8'hFF, F_VALID, 8'h00);
    // Write-only and write-one-to-clear keep their loaded read image.
    queue_access(REQ_WRITE,  8'h00, 3'd0, 8'h0F, F_VALID | F_WO, 8'h03);
    queue_access(REQ_READ,   8'h00, 3'd0, 8'hFF, F_VALID | F_WO, 8'h00);
    queue_access(REQ_WRITE,  8'h20, 3'd2, 8'h01, F_VALID | F_W1C, 8'h01);
    queue_access(REQ_READ,   8'h20, 3'd0, 8'hFF, F_VALID | F_W1C, 8'h00);
    queue_access(REQ_WRITE,  8'h20, 3'd1, 8'h3F, 4'hF, 8'h2A);
    queue_access(REQ_READ,   8'h20, 3'd1, 8'h3F, 4'hF, 8'h00);
    // Invalid register and unused request code.
    queue_access(REQ_READ,   8'h20, 3'd0, 8'hFF, 4'h0, 8'h00);
    queue_access(REQ_WRITE,  8'h81, 3'd3, 8'hFF, 4'hE, 8'hFF);
    queue_access(REQ_UNUSED, 8'hFF, 3'd7, 8'hFF, 4'hF, 8'hFF);
    queue_access(REQ_WRITE,  8'hC8, 3'd6, 8'h00, F_VALID, 8'hFF);
    queue_access(REQ_WRITE,  8'hC8, 3'd0, 8'hF0, F_VALID, 8'h5C);
    queue_access(REQ_FLUSH,  8'h00, 3'd0, 8'h00, 4'h0, 8'h00);
    queue_access(REQ_READ,   8'hC8, 3'd4, 8'h0F, F_VALID, 8'h00);
    wait_drained();

    // Random phases; each drains fully before the next one starts.
    run_phase(0, 0);
    run_phase(75, 0);
    run_phase(0, 75);
    run_phase(12, 12);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d reads, %0d writes, %0d flushes, %0d unused, %0d invalid.",
             accepted_count, n_reads, n_writes, n_flushes, n_unused, n_invalid);
    $display("Register loads: %0d, write-backs: %0d, mismatching fields: %0d.",
             n_loads, n_writebacks, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rfac_pkg.sv
src/rfac_store.sv
src/register_field_access_cache_top.sv
src/rfac_checker.sv
tb/tb_top.sv
